### design/dsnp_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and character classes for the decimal SI number parser.
// Has no dependencies. Used by decimal_si_number_parser_unit.
package dsnp_pkg;

  // mantissa digits kept before the token is marked as too long
  localparam int unsigned MAX_DIGITS = 18;

  // most exponent digits for a valid real reading
  localparam int unsigned MAX_EXP_DIGITS = 9;

  // most integer digits for a valid integer reading
  localparam int unsigned MAX_INT_DIGITS = 9;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_UP_G  = 8'h47;
  localparam logic [7:0] CH_UP_K  = 8'h4B;
  localparam logic [7:0] CH_UP_M  = 8'h4D;
  localparam logic [7:0] CH_UP_T  = 8'h54;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_LO_M  = 8'h6D;
  localparam logic [7:0] CH_LO_N  = 8'h6E;
  localparam logic [7:0] CH_LO_P  = 8'h70;
  localparam logic [7:0] CH_LO_U  = 8'h75;

  // parse phase
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_LEAD      = 3'd1,
    PH_INT       = 3'd2,
    PH_FRAC      = 3'd3,
    PH_SUFFIX    = 3'd4,
    PH_EXP_START = 3'd5,
    PH_EXP_SIGN  = 3'd6,
    PH_EXP_DIG   = 3'd7
  } phase_e;

  // what one character does to the parse state
  typedef struct packed {
    logic start;       // first character: drop the open token
    logic set_neg;     // mantissa sign character
    logic add_dig;     // mantissa digit
    logic add_frac;    // mantissa digit after the point
    logic set_prefix;  // SI prefix letter
    logic exp_dig;     // exponent digit
    logic set_exp_neg; // exponent sign character
    logic emit;        // token ends here
    logic real_cand;   // real reading valid so far
    logic int_ok;      // integer reading valid
  } dsnp_action_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  function automatic logic is_term(input logic [7:0] c);
    return (c == CH_NUL) || (c == CH_SPACE) || (c == CH_TAB) || (c == CH_RBRK) ||
           (c == CH_RPAR) || (c == CH_CR) || (c == CH_LF);
  endfunction

  // decimal exponent of an SI prefix letter, zero for anything else
  function automatic logic signed [4:0] prefix_of(input logic [7:0] c);
    logic signed [4:0] v;
    v = 5'sd0;
    unique case (c)
      CH_LO_P: v = -5'sd12;
      CH_LO_N: v = -5'sd9;
      CH_LO_U: v = -5'sd6;
      CH_LO_M: v = -5'sd3;
      CH_UP_K: v = 5'sd3;
      CH_UP_M: v = 5'sd6;
      CH_UP_G: v = 5'sd9;
      CH_UP_T: v = 5'sd12;
      default: v = 5'sd0;
    endcase
    return v;
  endfunction

  function automatic logic is_prefix(input logic [7:0] c);
    return prefix_of(c) != 5'sd0;
  endfunction

endpackage

### design/decimal_si_number_parser_unit.sv
`timescale 1ns / 1ps
// Streaming decimal number parser with SI prefix or exponent suffix.
// Depends on dsnp_pkg for character classes, the phase enum and the action struct.
//
// Usage:
//  - input channel: one character per transfer on ch_i, with first_i high on
//    the first character of a token (this drops any unfinished token)
//  - output channel: one transfer on the character that ends a token, with the
//    integer reading (int_ok_o, int_value_o), the real reading (real_ok_o,
//    mantissa_o, dec_exponent_o) and the ending character end_char_o
//  - characters inside a token and characters outside any token give nothing
//  - a transfer happens at a rising edge with valid high and stall low
//  - path: a character goes into the input register, and its result into the
//    result register before it is shown
//  - throughput: one character per cycle while the receiver does not stall; each
//    character needs one multiply-by-ten-and-add on the 60-bit digit accumulator
//  - when the receiver stalls, the result register holds; one more character
//    waits in the input register, after which in_stall_o goes high
//  - reset clears both registers' valid flags and the parse state to idle
module decimal_si_number_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // character channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  input  logic        first_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        int_ok_o,
  output logic signed [30:0] int_value_o,
  output logic        real_ok_o,
  output logic signed [60:0] mantissa_o,
  output logic signed [30:0] dec_exponent_o,
  output logic [7:0]  end_char_o
);

  // input register
  logic       in_valid_q;
  logic [7:0] ch_q;
  logic       first_q;

  // parse state
  dsnp_pkg::phase_e  phase_q, phase_d;
  logic              neg_q, neg_d;
  logic [59:0]       acc_q, acc_d;
  logic [4:0]        dcnt_q, dcnt_d;
  logic [4:0]        fcnt_q, fcnt_d;
  logic signed [4:0] pexp_q, pexp_d;
  logic              eneg_q, eneg_d;
  logic [29:0]       eacc_q, eacc_d;
  logic [3:0]        ecnt_q, ecnt_d;
  logic              many_q, many_d;

  // state as seen by this character (cleared on a first character)
  dsnp_pkg::phase_e  ph_eff;
  logic              neg_e;
  logic [59:0]       acc_e;
  logic [4:0]        dcnt_e;
  logic [4:0]        fcnt_e;
  logic signed [4:0] pexp_e;
  logic              eneg_e;
  logic [29:0]       eacc_e;
  logic [3:0]        ecnt_e;
  logic              many_e;

  dsnp_pkg::dsnp_action_t act;
  logic [3:0]             dval;
  logic                   advance;

  // result register
  logic              out_valid_q;
  logic              int_ok_q, int_ok_d;
  logic signed [30:0] int_value_q, int_value_d;
  logic              real_ok_q, real_ok_d;
  logic signed [60:0] mant_q, mant_d;
  logic signed [30:0] dexp_q, dexp_d;
  logic [7:0]        end_char_q;

  logic signed [60:0] signed_acc;
  logic signed [31:0] exp_sum;

  // handshake
  assign advance    = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      ch_q    <= ch_i;
      first_q <= first_i;
    end
  end

  // effective state for the held character
  always_comb begin
    if (first_q) begin
      ph_eff = dsnp_pkg::PH_LEAD;
      neg_e  = 1'b0;
      acc_e  = '0;
      dcnt_e = '0;
      fcnt_e = '0;
      pexp_e = '0;
      eneg_e = 1'b0;
      eacc_e = '0;
      ecnt_e = '0;
      many_e = 1'b0;
    end else begin
      ph_eff = phase_q;
      neg_e  = neg_q;
      acc_e  = acc_q;
      dcnt_e = dcnt_q;
      fcnt_e = fcnt_q;
      pexp_e = pexp_q;
      eneg_e = eneg_q;
      eacc_e = eacc_q;
      ecnt_e = ecnt_q;
      many_e = many_q;
    end
  end

  // next phase and character action
  always_comb begin
    act     = '0;
    phase_d = phase_q;
    act.start = first_q;
    if (first_q && dsnp_pkg::is_sign(ch_q)) begin
      act.set_neg = 1'b1;
      phase_d     = dsnp_pkg::PH_LEAD;
    end else begin
      phase_d = ph_eff;
      unique case (ph_eff)
        dsnp_pkg::PH_IDLE: begin
          phase_d = dsnp_pkg::PH_IDLE;
        end
        dsnp_pkg::PH_LEAD: begin
          if (dsnp_pkg::is_digit(ch_q)) begin
            act.add_dig = 1'b1;
            phase_d     = dsnp_pkg::PH_INT;
          end else if (ch_q == dsnp_pkg::CH_POINT) begin
            phase_d = dsnp_pkg::PH_FRAC;
          end else begin
            act.emit = 1'b1;
          end
        end
        dsnp_pkg::PH_INT, dsnp_pkg::PH_FRAC: begin
          if (dsnp_pkg::is_digit(ch_q)) begin
            act.add_dig  = 1'b1;
            act.add_frac = (ph_eff == dsnp_pkg::PH_FRAC);
          end else if (ch_q == dsnp_pkg::CH_POINT && ph_eff == dsnp_pkg::PH_INT) begin
            phase_d = dsnp_pkg::PH_FRAC;
          end else if (dcnt_e == '0) begin
            act.emit = 1'b1;
          end else if (dsnp_pkg::is_prefix(ch_q)) begin
            act.set_prefix = 1'b1;
            phase_d        = dsnp_pkg::PH_SUFFIX;
          end else if (ch_q == dsnp_pkg::CH_LO_E || ch_q == dsnp_pkg::CH_UP_E) begin
            phase_d = dsnp_pkg::PH_EXP_START;
          end else if (dsnp_pkg::is_term(ch_q)) begin
            act.emit      = 1'b1;
            act.real_cand = 1'b1;
            act.int_ok    = (ph_eff == dsnp_pkg::PH_INT) &&
                            (dcnt_e <= 5'(dsnp_pkg::MAX_INT_DIGITS));
          end else begin
            act.emit = 1'b1;
          end
        end
        dsnp_pkg::PH_SUFFIX: begin
          act.emit      = 1'b1;
          act.real_cand = dsnp_pkg::is_term(ch_q);
        end
        dsnp_pkg::PH_EXP_START, dsnp_pkg::PH_EXP_SIGN, dsnp_pkg::PH_EXP_DIG: begin
          if (dsnp_pkg::is_digit(ch_q)) begin
            act.exp_dig = 1'b1;
            phase_d     = dsnp_pkg::PH_EXP_DIG;
          end else if (ph_eff == dsnp_pkg::PH_EXP_START && dsnp_pkg::is_sign(ch_q)) begin
            act.set_exp_neg = 1'b1;
            phase_d         = dsnp_pkg::PH_EXP_SIGN;
          end else begin
            act.emit      = 1'b1;
            act.real_cand = (ph_eff == dsnp_pkg::PH_EXP_DIG) && dsnp_pkg::is_term(ch_q);
          end
        end
        default: begin
          phase_d = dsnp_pkg::PH_IDLE;
        end
      endcase
      if (act.emit) begin
        phase_d = dsnp_pkg::PH_IDLE;
      end
    end
  end

  // datapath update: accumulate digits, prefix and exponent
  assign dval = ch_q[3:0];

  always_comb begin
    neg_d  = neg_e;
    acc_d  = acc_e;
    dcnt_d = dcnt_e;
    fcnt_d = fcnt_e;
    pexp_d = pexp_e;
    eneg_d = eneg_e;
    eacc_d = eacc_e;
    ecnt_d = ecnt_e;
    many_d = many_e;
    if (act.set_neg) begin
      neg_d = (ch_q == dsnp_pkg::CH_MINUS);
    end
    if (act.add_dig) begin
      if (dcnt_e < 5'(dsnp_pkg::MAX_DIGITS)) begin
        acc_d = (acc_e << 3) + (acc_e << 1) + 60'(dval);
        if (act.add_frac && fcnt_e != 5'd31) begin
          fcnt_d = fcnt_e + 5'd1;
        end
      end else begin
        many_d = 1'b1;
      end
      if (dcnt_e != 5'd31) begin
        dcnt_d = dcnt_e + 5'd1;
      end
    end
    if (act.set_prefix) begin
      pexp_d = dsnp_pkg::prefix_of(ch_q);
    end
    if (act.set_exp_neg) begin
      eneg_d = (ch_q == dsnp_pkg::CH_MINUS);
    end
    if (act.exp_dig) begin
      if (ecnt_e < 4'(dsnp_pkg::MAX_EXP_DIGITS)) begin
        eacc_d = (eacc_e << 3) + (eacc_e << 1) + 30'(dval);
      end
      if (ecnt_e != 4'd15) begin
        ecnt_d = ecnt_e + 4'd1;
      end
    end
  end

  // result fields for an ending character
  assign signed_acc = neg_e ? -$signed({1'b0, acc_e}) : $signed({1'b0, acc_e});
  assign exp_sum    = 32'(pexp_e) - $signed({27'd0, fcnt_e}) +
                      (eneg_e ? -$signed({2'b00, eacc_e}) : $signed({2'b00, eacc_e}));

  always_comb begin
    int_ok_d    = act.int_ok;
    int_value_d = act.int_ok ? signed_acc[30:0] : '0;
    real_ok_d   = act.real_cand && !many_e &&
                  (ecnt_e <= 4'(dsnp_pkg::MAX_EXP_DIGITS));
    mant_d      = real_ok_d ? signed_acc : '0;
    dexp_d      = real_ok_d ? exp_sum[30:0] : '0;
  end

  // parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dsnp_pkg::PH_IDLE;
      neg_q   <= 1'b0;
      acc_q   <= '0;
      dcnt_q  <= '0;
      fcnt_q  <= '0;
      pexp_q  <= '0;
      eneg_q  <= 1'b0;
      eacc_q  <= '0;
      ecnt_q  <= '0;
      many_q  <= 1'b0;
    end else if (advance) begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      acc_q   <= acc_d;
      dcnt_q  <= dcnt_d;
      fcnt_q  <= fcnt_d;
      pexp_q  <= pexp_d;
      eneg_q  <= eneg_d;
      eacc_q  <= eacc_d;
      ecnt_q  <= ecnt_d;
      many_q  <= many_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!(out_valid_q && out_stall_i)) begin
      out_valid_q <= in_valid_q && act.emit;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (advance && act.emit) begin
      int_ok_q    <= int_ok_d;
      int_value_q <= int_value_d;
      real_ok_q   <= real_ok_d;
      mant_q      <= mant_d;
      dexp_q      <= dexp_d;
      end_char_q  <= ch_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign int_ok_o       = int_ok_q;
  assign int_value_o    = int_value_q;
  assign real_ok_o      = real_ok_q;
  assign mantissa_o     = mant_q;
  assign dec_exponent_o = dexp_q;
  assign end_char_o     = end_char_q;

endmodule
